FILE: rtl/isnra_pkg.sv
// ----------------------------------------------------------------------------
// isnra_pkg
// Shared types, constants and sine/cosine tables for the augmentation block.
// ----------------------------------------------------------------------------
package isnra_pkg;

    localparam int IMAGE_SIDE_DEF = 28;
    localparam int ONE_Q14        = 16384;
    localparam int FRAC_BITS      = 14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROWCOL,
        ST_ROTMUL,
        ST_ROTSUM,
        ST_FETCH,
        ST_MULT,
        ST_ACC,
        ST_DONE
    } state_t;

    // entry k holds angle k - 16 degrees, q1.14
    function automatic logic signed [15:0] sin_q14(input logic [4:0] k);
        logic signed [15:0] v;
        case (k)
            5'd0:  v = -16'sd4516;
            5'd1:  v = -16'sd4240;
            5'd2:  v = -16'sd3964;
            5'd3:  v = -16'sd3686;
            5'd4:  v = -16'sd3406;
            5'd5:  v = -16'sd3126;
            5'd6:  v = -16'sd2845;
            5'd7:  v = -16'sd2563;
            5'd8:  v = -16'sd2280;
            5'd9:  v = -16'sd1997;
            5'd10: v = -16'sd1713;
            5'd11: v = -16'sd1428;
            5'd12: v = -16'sd1143;
            5'd13: v = -16'sd857;
            5'd14: v = -16'sd572;
            5'd15: v = -16'sd286;
            5'd16: v = 16'sd0;
            5'd17: v = 16'sd286;
            5'd18: v = 16'sd572;
            5'd19: v = 16'sd857;
            5'd20: v = 16'sd1143;
            5'd21: v = 16'sd1428;
            5'd22: v = 16'sd1713;
            5'd23: v = 16'sd1997;
            5'd24: v = 16'sd2280;
            5'd25: v = 16'sd2563;
            5'd26: v = 16'sd2845;
            5'd27: v = 16'sd3126;
            5'd28: v = 16'sd3406;
            5'd29: v = 16'sd3686;
            5'd30: v = 16'sd3964;
            default: v = 16'sd4240;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] cos_q14(input logic [4:0] k);
        logic signed [15:0] v;
        case (k)
            5'd0:  v = 16'sd15749;
            5'd1:  v = 16'sd15826;
            5'd2:  v = 16'sd15897;
            5'd3:  v = 16'sd15964;
            5'd4:  v = 16'sd16026;
            5'd5:  v = 16'sd16083;
            5'd6:  v = 16'sd16135;
            5'd7:  v = 16'sd16182;
            5'd8:  v = 16'sd16225;
            5'd9:  v = 16'sd16262;
            5'd10: v = 16'sd16294;
            5'd11: v = 16'sd16322;
            5'd12: v = 16'sd16344;
            5'd13: v = 16'sd16362;
            5'd14: v = 16'sd16374;
            5'd15: v = 16'sd16382;
            5'd16: v = 16'sd16384;
            5'd17: v = 16'sd16382;
            5'd18: v = 16'sd16374;
            5'd19: v = 16'sd16362;
            5'd20: v = 16'sd16344;
            5'd21: v = 16'sd16322;
            5'd22: v = 16'sd16294;
            5'd23: v = 16'sd16262;
            5'd24: v = 16'sd16225;
            5'd25: v = 16'sd16182;
            5'd26: v = 16'sd16135;
            5'd27: v = 16'sd16083;
            5'd28: v = 16'sd16026;
            5'd29: v = 16'sd15964;
            5'd30: v = 16'sd15897;
            default: v = 16'sd15826;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/isnra_store.sv
// ----------------------------------------------------------------------------
// isnra_store
// Image and noise memories, one write port and one registered read port each.
// ----------------------------------------------------------------------------
module isnra_store #(
    parameter int DEPTH = isnra_pkg::IMAGE_SIDE_DEF * isnra_pkg::IMAGE_SIDE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [15:0]   wr_pixel,
    input  logic signed [15:0]   wr_noise,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_img_addr,
    input  logic [AW-1:0]        rd_noise_addr,
    output logic signed [15:0]   img_data,
    output logic signed [15:0]   noise_data
);

    logic signed [15:0] img_mem   [DEPTH];
    logic signed [15:0] noise_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            img_mem[wr_addr]   <= wr_pixel;
            noise_mem[wr_addr] <= wr_noise;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            img_data   <= img_mem[rd_img_addr];
            noise_data <= noise_mem[rd_noise_addr];
        end
    end

endmodule

FILE: rtl/image_shift_noise_rotate_augment_core.sv
// ----------------------------------------------------------------------------
// image_shift_noise_rotate_augment_core
// Shift, noise and bilinear rotation read-out over a stored image.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one word per item. operation 0
// writes pixel_value and noise_value at an in-range pixel_index and gives
// no result; operation 1 returns one augmented_pixel on the output channel
// (out_valid/out_ready).
// A read runs the index split (ST_DIV, ST_ROWCOL), then, when rotation is
// on, the rotated coordinate (ST_ROTMUL, ST_ROTSUM), then per neighbour a
// memory read, weight times pixel and accumulate (ST_FETCH, ST_MULT, ST_ACC)
// for 1 or 4 neighbours (none when the index or the rotated point is out of
// range), and rounds in ST_DONE; the next item is taken once the sequencer
// is back in idle. The single read port of each store sets the
// per-neighbour cost; one read is in flight at a time.
// in_ready is high only while the sequencer is idle; a load is taken even
// while a result waits in the output register, and a read finishes into it
// once the receiver has taken the previous word.
// Reset clears the sequencer and the output valid; the stores are not
// cleared and read undefined until written.
// ----------------------------------------------------------------------------
module image_shift_noise_rotate_augment_core #(
    parameter int IMAGE_SIDE = isnra_pkg::IMAGE_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [9:0]         pixel_index,
    input  logic signed [15:0] pixel_value,
    input  logic signed [15:0] noise_value,
    input  logic               shift_on,
    input  logic signed [2:0]  shift_cols,
    input  logic signed [2:0]  shift_rows,
    input  logic               noise_on,
    input  logic               rotate_on,
    input  logic signed [4:0]  angle_degrees,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] augmented_pixel
);

    localparam int DEPTH = IMAGE_SIDE * IMAGE_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(IMAGE_SIDE);
    localparam int RECIP = (65536 + IMAGE_SIDE - 1) / IMAGE_SIDE;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int CTR   = (IMAGE_SIDE - 1) * isnra_pkg::ONE_Q14;
    localparam int ONE   = isnra_pkg::ONE_Q14;
    localparam int FB    = isnra_pkg::FRAC_BITS;

    isnra_pkg::state_t state_reg, state_next;

    logic              sh_on_reg, nz_on_reg, rot_on_reg, zero_reg;
    logic signed [2:0] sc_reg, sr_reg;
    logic [4:0]        ang_reg;
    logic [9:0]        idx_reg;
    logic [9:0]        est_reg;
    logic [CW-1:0]     row_reg, col_reg, x0_reg, y0_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic signed [23:0] m_cx_reg, m_sy_reg, m_sx_reg, m_cy_reg;
    logic [1:0]        nbr_reg, nbr_last_reg;
    logic signed [31:0] w_reg;
    logic              img_ok_reg;
    logic signed [49:0] prod_reg, acc_reg;
    logic              out_valid_reg;
    logic signed [15:0] out_pix_reg;

    logic              accept, load_out, rd_en, wr_en;
    logic              idx_in_range;
    logic [AW-1:0]     rd_img_addr, rd_noise_addr;
    logic signed [15:0] img_data, noise_data;

    // index split
    logic [9+RW:0]     quot_full;
    logic signed [17:0] rem_s;
    // rotation
    logic [4:0]        tab_k;
    logic signed [15:0] cs, sn;
    logic signed [7:0] ux, uy;
    logic signed [25:0] xs, ys;
    logic signed [24:0] xr, yr;
    logic [10:0]       x0_full, y0_full;
    logic              x_ok, y_ok;
    logic signed [15:0] dx_n, dy_n;
    // fetch
    logic [CW:0]       nr, nc;
    logic signed [CW+3:0] src_r, src_c;
    logic              src_ok;
    logic signed [15:0] fx, fy;
    // multiply
    logic signed [17:0] pix_v;
    // round
    logic signed [49:0] rounded;
    logic signed [15:0] sat_pix;

    assign accept       = in_valid && in_ready;
    assign idx_in_range = {3'b000, pixel_index} < 13'(DEPTH);
    assign wr_en        = accept && !operation && idx_in_range;

    isnra_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk           (clk),
        .wr_en         (wr_en),
        .wr_addr       (AW'(pixel_index)),
        .wr_pixel      (pixel_value),
        .wr_noise      (noise_value),
        .rd_en         (rd_en),
        .rd_img_addr   (rd_img_addr),
        .rd_noise_addr (rd_noise_addr),
        .img_data      (img_data),
        .noise_data    (noise_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isnra_pkg::ST_IDLE:
                if (accept && operation)
                    state_next = idx_in_range ? isnra_pkg::ST_DIV : isnra_pkg::ST_DONE;
            isnra_pkg::ST_DIV:    state_next = isnra_pkg::ST_ROWCOL;
            isnra_pkg::ST_ROWCOL:
                state_next = rot_on_reg ? isnra_pkg::ST_ROTMUL : isnra_pkg::ST_FETCH;
            isnra_pkg::ST_ROTMUL: state_next = isnra_pkg::ST_ROTSUM;
            isnra_pkg::ST_ROTSUM:
                state_next = (x_ok && y_ok) ? isnra_pkg::ST_FETCH : isnra_pkg::ST_DONE;
            isnra_pkg::ST_FETCH:  state_next = isnra_pkg::ST_MULT;
            isnra_pkg::ST_MULT:   state_next = isnra_pkg::ST_ACC;
            isnra_pkg::ST_ACC:
                state_next = (nbr_reg == nbr_last_reg) ? isnra_pkg::ST_DONE
                                                       : isnra_pkg::ST_FETCH;
            isnra_pkg::ST_DONE:
                if (load_out)
                    state_next = isnra_pkg::ST_IDLE;
            default: state_next = isnra_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            isnra_pkg::ST_IDLE:  in_ready = 1'b1;
            isnra_pkg::ST_FETCH: rd_en    = 1'b1;
            isnra_pkg::ST_DONE:  load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // datapath combinational terms
    always_comb
    begin
        quot_full = (10 + RW)'(idx_reg) * (10 + RW)'(RECIP);
        rem_s = signed'(18'(idx_reg)) - signed'(18'(est_reg) * 18'(IMAGE_SIDE));

        tab_k = ang_reg ^ 5'b10000;
        cs    = isnra_pkg::cos_q14(tab_k);
        sn    = isnra_pkg::sin_q14(tab_k);
        ux    = signed'(8'({col_reg, 1'b0})) - 8'(IMAGE_SIDE - 1);
        uy    = signed'(8'({row_reg, 1'b0})) - 8'(IMAGE_SIDE - 1);

        xs = 26'(m_cx_reg) - 26'(m_sy_reg) + 26'(CTR);
        ys = 26'(m_sx_reg) + 26'(m_cy_reg) + 26'(CTR);
        xr = 25'(xs >>> 1);
        yr = 25'(ys >>> 1);

        // integer part truncated toward zero
        if (xr < 0)
        begin
            x_ok    = xr > -25'sd16384;
            x0_full = '0;
            dx_n    = xr[15:0];
        end
        else
        begin
            x0_full = xr[24:FB];
            x_ok    = x0_full < 11'(IMAGE_SIDE - 1);
            dx_n    = {2'b00, xr[FB-1:0]};
        end
        if (yr < 0)
        begin
            y_ok    = yr > -25'sd16384;
            y0_full = '0;
            dy_n    = yr[15:0];
        end
        else
        begin
            y0_full = yr[24:FB];
            y_ok    = y0_full < 11'(IMAGE_SIDE - 1);
            dy_n    = {2'b00, yr[FB-1:0]};
        end

        // neighbour bit 0 steps the column, bit 1 the row
        nr = (CW + 1)'(y0_reg) + (CW + 1)'(nbr_reg[1]);
        nc = (CW + 1)'(x0_reg) + (CW + 1)'(nbr_reg[0]);
        src_r = signed'((CW + 4)'(nr));
        src_c = signed'((CW + 4)'(nc));
        if (sh_on_reg)
        begin
            src_r = src_r - (CW + 4)'(sr_reg);
            src_c = src_c - (CW + 4)'(sc_reg);
        end
        src_ok = src_r >= 0 && src_r < (CW + 4)'(IMAGE_SIDE)
              && src_c >= 0 && src_c < (CW + 4)'(IMAGE_SIDE);
        rd_img_addr = src_ok ? AW'(src_r) + AW'(src_c) * AW'(IMAGE_SIDE) : '0;
        rd_noise_addr = AW'(nr) + AW'(nc) * AW'(IMAGE_SIDE);
        fx = nbr_reg[0] ? dx_reg : 16'(ONE) - dx_reg;
        fy = nbr_reg[1] ? dy_reg : 16'(ONE) - dy_reg;

        pix_v = img_ok_reg ? 18'(img_data) : '0;
        if (nz_on_reg)
        begin
            pix_v = pix_v + 18'(noise_data);
            if (pix_v < 0)
                pix_v = '0;
            else if (pix_v > 18'sd4096)
                pix_v = 18'sd4096;
        end

        rounded = (acc_reg + 50'sd134217728) >>> 28;
        if (zero_reg)
            sat_pix = '0;
        else if (rounded > 50'sd32767)
            sat_pix = 16'sd32767;
        else if (rounded < -50'sd32768)
            sat_pix = -16'sd32768;
        else
            sat_pix = rounded[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isnra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            isnra_pkg::ST_IDLE:
                if (accept)
                begin
                    idx_reg    <= pixel_index;
                    sh_on_reg  <= shift_on;
                    sc_reg     <= shift_cols;
                    sr_reg     <= shift_rows;
                    nz_on_reg  <= noise_on;
                    rot_on_reg <= rotate_on;
                    ang_reg    <= angle_degrees;
                    zero_reg   <= !idx_in_range;
                    acc_reg    <= '0;
                    nbr_reg    <= '0;
                end
            isnra_pkg::ST_DIV:
                est_reg <= 10'(quot_full >> 16);
            isnra_pkg::ST_ROWCOL:
            begin
                if (rem_s < 0)
                begin
                    col_reg <= CW'(est_reg - 10'd1);
                    row_reg <= CW'(rem_s + 18'(IMAGE_SIDE));
                    x0_reg  <= CW'(est_reg - 10'd1);
                    y0_reg  <= CW'(rem_s + 18'(IMAGE_SIDE));
                end
                else
                begin
                    col_reg <= CW'(est_reg);
                    row_reg <= CW'(rem_s);
                    x0_reg  <= CW'(est_reg);
                    y0_reg  <= CW'(rem_s);
                end
                dx_reg       <= '0;
                dy_reg       <= '0;
                nbr_last_reg <= rot_on_reg ? 2'd3 : 2'd0;
            end
            isnra_pkg::ST_ROTMUL:
            begin
                m_cx_reg <= 24'(cs) * 24'(ux);
                m_sy_reg <= 24'(sn) * 24'(uy);
                m_sx_reg <= 24'(sn) * 24'(ux);
                m_cy_reg <= 24'(cs) * 24'(uy);
            end
            isnra_pkg::ST_ROTSUM:
            begin
                x0_reg   <= CW'(x0_full);
                y0_reg   <= CW'(y0_full);
                dx_reg   <= dx_n;
                dy_reg   <= dy_n;
                zero_reg <= !(x_ok && y_ok);
            end
            isnra_pkg::ST_FETCH:
            begin
                w_reg      <= 32'(fx) * 32'(fy);
                img_ok_reg <= src_ok;
            end
            isnra_pkg::ST_MULT:
                prod_reg <= 50'(w_reg) * 50'(pix_v);
            isnra_pkg::ST_ACC:
            begin
                acc_reg <= acc_reg + prod_reg;
                nbr_reg <= nbr_reg + 2'd1;
            end
            isnra_pkg::ST_DONE:
                if (load_out)
                    out_pix_reg <= sat_pix;
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign augmented_pixel = out_pix_reg;

    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation) |=> !in_ready)
        else $error("input taken while a read is in progress");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isnra_pkg::ST_DONE && (!out_valid || out_ready)) |=> out_valid)
        else $error("finished read did not reach the output register");

    a_last_nbr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isnra_pkg::ST_ACC && nbr_reg == nbr_last_reg)
        |=> state_reg == isnra_pkg::ST_DONE)
        else $error("neighbour loop ran past its last entry");

endmodule
